/* rtl/dau_pkg.sv */
// Shared types and constants for the decimal arithmetic unit.
// Used by dau_front, dau_queue, dau_back and decimal_arithmetic_unit_top.
package dau_pkg;

  localparam int OPERAND_BITS = 128;
  localparam int WORK_BITS    = 256;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;
  localparam logic [2:0] OP_ABS = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_PREC     = 2'd2;
  localparam logic [1:0] ST_DIV_OVF  = 2'd3;

  localparam logic [1:0] REG_PRECISION = 2'd0;
  localparam logic [1:0] REG_SCALE     = 2'd1;

  localparam logic [5:0] PRECISION_RESET = 6'd38;
  localparam logic [5:0] SCALE_RESET     = 6'd0;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    lneg;
    logic [OPERAND_BITS-1:0] lmag;
    logic                    rneg;
    logic [OPERAND_BITS-1:0] rmag;
  } item_t;

endpackage

/* rtl/dau_front.sv */
// Front end: splits both operands into sign and magnitude for the queue.
// Depends on dau_pkg.
module dau_front (
  input  logic [2:0]          in_kind,
  input  logic [63:0]         in_left_low,
  input  logic [63:0]         in_left_high,
  input  logic [63:0]         in_right_low,
  input  logic [63:0]         in_right_high,
  output dau_pkg::item_t      item
);

  logic [dau_pkg::OPERAND_BITS-1:0] lv;
  logic [dau_pkg::OPERAND_BITS-1:0] rv;

  assign lv = {in_left_high, in_left_low};
  assign rv = {in_right_high, in_right_low};

  always_comb begin
    item.kind = in_kind;
    item.lneg = lv[dau_pkg::OPERAND_BITS-1];
    item.lmag = lv[dau_pkg::OPERAND_BITS-1] ? (~lv + 1'b1) : lv;
    item.rneg = rv[dau_pkg::OPERAND_BITS-1];
    item.rmag = rv[dau_pkg::OPERAND_BITS-1] ? (~rv + 1'b1) : rv;
  end

endmodule

/* rtl/dau_queue.sv */
// Short queue of classified items between the front and back ends.
// Depends on dau_pkg.
module dau_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dau_pkg::item_t push_item,
  input  logic           pop,
  output dau_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  dau_pkg::item_t mem_r [dau_pkg::QUEUE_DEPTH];
  logic [dau_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [dau_pkg::QPTR_W:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (dau_pkg::QPTR_W+1)'(dau_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (dau_pkg::QPTR_W+1)'(push) - (dau_pkg::QPTR_W+1)'(pop);
    end
  end

endmodule

/* rtl/dau_back.sv */
// Back end: sequencer with a shift-add multiplier and a restoring divider.
// Depends on dau_pkg.
module dau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [5:0]     precision,
  input  logic [5:0]     scale,
  input  logic           q_empty,
  input  dau_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  output logic [63:0]    out_result_low,
  output logic [63:0]    out_result_high,
  output logic [1:0]     out_status
);

  localparam int W = dau_pkg::WORK_BITS;
  localparam int N = dau_pkg::OPERAND_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POW  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [8:0]   cnt_r, cnt_nxt;
  logic [2:0]   kind_r;
  logic         ln_r, rn_r;
  logic [N-1:0] lm_r, rm_r;
  logic [W-1:0] ps_r, ps_nxt, pp_r, pp_nxt;
  logic [W-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [N-1:0] mp_r, mp_nxt;
  logic         ovf_r, ovf_nxt;
  logic [W-1:0] num_r, num_nxt, den_r, den_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         resn_r, resn_nxt;
  logic [1:0]   st_r, st_nxt;

  logic [W+1:0] mul_sum;
  logic [W+1:0] div_diff;
  logic [W:0]   div_sh;
  logic [N:0]   sum_ab, dif_ab, dif_ba;
  logic         eff_rn;
  logic [N-1:0] fin_mag;

  assign pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    mul_sum  = {1'b0, acc_r, 1'b0} + {2'b0, mc_r};
    div_sh   = {rem_r, num_r[W-1]};
    div_diff = {1'b0, div_sh} - {2'b0, den_r};
    sum_ab   = {1'b0, lm_r} + {1'b0, rm_r};
    dif_ab   = {1'b0, lm_r} - {1'b0, rm_r};
    dif_ba   = {1'b0, rm_r} - {1'b0, lm_r};
    eff_rn   = (kind_r == dau_pkg::OP_SUB) ? (!rn_r && (rm_r != '0)) : rn_r;
    fin_mag  = res_r[N-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ps_nxt    = ps_r;
    pp_nxt    = pp_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    ovf_nxt   = ovf_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    resn_nxt  = resn_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = S_POW;
          cnt_nxt   = '0;
          ps_nxt    = W'(1);
          pp_nxt    = W'(1);
          st_nxt    = dau_pkg::ST_OK;
          res_nxt   = '0;
          resn_nxt  = 1'b0;
        end
      end
      S_POW: begin
        if (cnt_r[5:0] < scale) begin
          ps_nxt = (ps_r << 3) + (ps_r << 1);
        end
        if (cnt_r[5:0] < precision) begin
          pp_nxt = (pp_r << 3) + (pp_r << 1);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[5:0] == 6'd63) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = S_FIN;
          case (kind_r)
            dau_pkg::OP_ADD, dau_pkg::OP_SUB: begin
              if (ln_r == eff_rn) begin
                res_nxt  = W'(sum_ab);
                resn_nxt = ln_r;
              end else if (lm_r == rm_r) begin
                res_nxt  = '0;
                resn_nxt = 1'b0;
              end else if (lm_r > rm_r) begin
                res_nxt  = W'(dif_ab);
                resn_nxt = ln_r;
              end else begin
                res_nxt  = W'(dif_ba);
                resn_nxt = eff_rn;
              end
            end
            dau_pkg::OP_MUL: begin
              mc_nxt    = W'(lm_r);
              mp_nxt    = rm_r;
              state_nxt = S_MUL;
            end
            dau_pkg::OP_DIV: begin
              if (rm_r == '0) begin
                st_nxt = dau_pkg::ST_DIV_ZERO;
              end else begin
                mc_nxt    = ps_nxt;
                mp_nxt    = lm_r;
                state_nxt = S_MUL;
              end
            end
            dau_pkg::OP_REM: begin
              if (rm_r == '0) begin
                st_nxt = dau_pkg::ST_DIV_ZERO;
              end else begin
                num_nxt   = W'(lm_r);
                den_nxt   = W'(rm_r);
                state_nxt = S_DIV;
              end
            end
            dau_pkg::OP_NEG: begin
              res_nxt  = W'(lm_r);
              resn_nxt = !ln_r && (lm_r != '0);
            end
            dau_pkg::OP_ABS: begin
              res_nxt  = W'(lm_r);
              resn_nxt = 1'b0;
            end
            default: begin
              res_nxt  = '0;
              resn_nxt = 1'b0;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = mp_r[N-1] ? mul_sum[W-1:0] : {acc_r[W-2:0], 1'b0};
        ovf_nxt = ovf_r | acc_r[W-1] | (mp_r[N-1] & (mul_sum[W+1:W] != 2'b00));
        mp_nxt  = {mp_r[N-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 9'(N-1)) begin
          cnt_nxt   = '0;
          num_nxt   = acc_nxt;
          state_nxt = S_DIV;
          if (kind_r == dau_pkg::OP_MUL) begin
            den_nxt = ps_r;
          end else begin
            den_nxt = W'(rm_r);
            if (ovf_nxt) begin
              st_nxt    = dau_pkg::ST_DIV_OVF;
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_DIV: begin
        num_nxt = {num_r[W-2:0], 1'b0};
        if (!div_diff[W+1]) begin
          rem_nxt = div_diff[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 9'(W-1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
          if (kind_r == dau_pkg::OP_REM) begin
            res_nxt  = rem_nxt;
            resn_nxt = ln_r;
          end else begin
            res_nxt  = quo_nxt;
            resn_nxt = ln_r ^ rn_r;
          end
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= (state_r == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head.kind;
      ln_r   <= head.lneg;
      lm_r   <= head.lmag;
      rn_r   <= head.rneg;
      rm_r   <= head.rmag;
    end
    ps_r   <= ps_nxt;
    pp_r   <= pp_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    ovf_r  <= ovf_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    res_r  <= res_nxt;
    resn_r <= resn_nxt;
    st_r   <= st_nxt;
    if (state_r == S_FIN) begin
      if (st_r != dau_pkg::ST_OK) begin
        {out_result_high, out_result_low} <= '0;
        out_status <= st_r;
      end else if (res_r >= pp_r) begin
        {out_result_high, out_result_low} <= '0;
        out_status <= dau_pkg::ST_PREC;
      end else begin
        {out_result_high, out_result_low} <= (resn_r && (res_r != '0)) ?
                                             (~fin_mag + 1'b1) : fin_mag;
        out_status <= dau_pkg::ST_OK;
      end
    end
  end

endmodule

/* rtl/decimal_arithmetic_unit_top.sv */
// Top level of the decimal arithmetic unit: configuration registers, front end,
// item queue and back end. Depends on dau_pkg, dau_front, dau_queue, dau_back.
//
//  Channel  Ports                                          Transfer
//  input    start, busy, in_kind, in_left_*, in_right_*    start && !busy
//  result   out_valid, out_result_*, out_status            out_valid, one cycle
//  config   cfg_we, cfg_index, cfg_data                    cfg_we
//
// Each item runs the power-of-ten sequencer in the back end. Add, subtract,
// negate and absolute value then finish; multiply and divide add a shift-add
// multiply and a restoring division, and remainder adds the division alone.
// Reset is synchronous and empties the queue. Busy is high while the queue of
// four items is full; the receiver cannot stall, so results never wait.
module decimal_arithmetic_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_left_low,
  input  logic [63:0] in_left_high,
  input  logic [63:0] in_right_low,
  input  logic [63:0] in_right_high,
  output logic        out_valid,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  logic [5:0]     precision_r, scale_r;
  dau_pkg::item_t front_item, head;
  logic           q_full, q_empty, pop, push;

  assign busy = q_full;
  assign push = start && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= dau_pkg::PRECISION_RESET;
      scale_r     <= dau_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dau_pkg::REG_PRECISION) begin
        precision_r <= cfg_data;
      end else if (cfg_index == dau_pkg::REG_SCALE) begin
        scale_r <= cfg_data;
      end
    end
  end

  dau_front u_front (
    .in_kind       (in_kind),
    .in_left_low   (in_left_low),
    .in_left_high  (in_left_high),
    .in_right_low  (in_right_low),
    .in_right_high (in_right_high),
    .item          (front_item)
  );

  dau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dau_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .precision       (precision_r),
    .scale           (scale_r),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .out_status      (out_status)
  );

endmodule

/* tb/tb_decimal_arithmetic_unit_top.sv */
// Self-checking testbench for decimal_arithmetic_unit_top: directed and random operations
// under several precision and scale settings, predicted in 256-bit arithmetic and checked.
// Depends on dau_pkg and decimal_arithmetic_unit_top.
module tb_decimal_arithmetic_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {ENTRY_OP, ENTRY_CFG, ENTRY_DRAIN} entry_t;

  typedef struct {
    entry_t      what;
    logic [2:0]  kind;
    logic [127:0] left;
    logic [127:0] right;
    logic [1:0]  index;
    logic [5:0]  value;
    int          idle_pct;
  } pending_t;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
    logic [1:0]  status;
  } decimal_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_left_low = '0;
  logic [63:0] in_left_high = '0;
  logic [63:0] in_right_low = '0;
  logic [63:0] in_right_high = '0;
  logic        out_valid;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  pending_t        pending_q[$];
  decimal_result_t expected_q[$];
  logic [5:0]      cur_precision = dau_pkg::PRECISION_RESET;
  logic [5:0]      cur_scale = dau_pkg::SCALE_RESET;
  int              errors = 0;
  int              settle = 0;
  int              quiet_cycles = 0;

  decimal_arithmetic_unit_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_left_low(in_left_low), .in_left_high(in_left_high),
    .in_right_low(in_right_low), .in_right_high(in_right_high),
    .out_valid(out_valid), .out_result_low(out_result_low),
    .out_result_high(out_result_high), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [255:0] magnitude(logic [127:0] v);
    logic [127:0] m;
    m = v[127] ? -v : v;
    return {128'd0, m};
  endfunction

  function automatic decimal_result_t compute_decimal(logic [2:0] kind, logic [127:0] a,
                                                      logic [127:0] b, logic [5:0] prec,
                                                      logic [5:0] sc);
    logic [255:0] am, bm, res, lim;
    logic [259:0] widened;
    logic an, bn, rneg;
    logic [1:0] st;
    decimal_result_t o;
    am = magnitude(a);
    bm = magnitude(b);
    an = a[127];
    bn = b[127];
    res = '0;
    rneg = 1'b0;
    st = dau_pkg::ST_OK;
    if (kind == dau_pkg::OP_SUB) begin
      bn = !bn && (bm != 0);
    end
    case (kind)
      dau_pkg::OP_ADD, dau_pkg::OP_SUB: begin
        if (an == bn) begin
          res = am + bm;
          rneg = an;
        end else if (am > bm) begin
          res = am - bm;
          rneg = an;
        end else if (bm > am) begin
          res = bm - am;
          rneg = bn;
        end
      end
      dau_pkg::OP_MUL: begin
        res = am * bm;
        for (int i = 0; i < sc; i++) res = res / 256'd10;
        rneg = an != bn;
      end
      dau_pkg::OP_DIV: begin
        if (bm == 0) begin
          st = dau_pkg::ST_DIV_ZERO;
        end else begin
          for (int i = 0; i < sc && st == dau_pkg::ST_OK; i++) begin
            widened = {4'd0, am} * 260'd10;
            if (widened[259:256] != 0) st = dau_pkg::ST_DIV_OVF;
            am = widened[255:0];
          end
          if (st == dau_pkg::ST_OK) res = am / bm;
          rneg = an != bn;
        end
      end
      dau_pkg::OP_REM: begin
        if (bm == 0) begin
          st = dau_pkg::ST_DIV_ZERO;
        end else begin
          res = am % bm;
          rneg = an;
        end
      end
      dau_pkg::OP_NEG: begin
        res = am;
        rneg = !an && (am != 0);
      end
      dau_pkg::OP_ABS: res = am;
      default: res = '0;
    endcase
    lim = 256'd1;
    for (int i = 0; i < prec; i++) lim = lim * 256'd10;
    if (st == dau_pkg::ST_OK && res >= lim) st = dau_pkg::ST_PREC;
    if (st != dau_pkg::ST_OK) begin
      res = '0;
    end else if (rneg) begin
      res = -res;
    end
    o.low = res[63:0];
    o.high = res[127:64];
    o.status = st;
    return o;
  endfunction

  function automatic logic [127:0] pick_operand();
    logic [127:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = {1'b0, {127{1'b1}}};
      2: v = {1'b1, 127'd0};
      3: v = {$urandom, $urandom, $urandom, $urandom};
      4, 5: v = 128'($urandom_range(0, 1000));
      6: v = {64'd0, $urandom, $urandom};
      default: v = {64'd0, $urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic add_op(logic [2:0] kind, logic [127:0] a, logic [127:0] b, int idle);
    pending_t p;
    p = '{ENTRY_OP, kind, a, b, dau_pkg::REG_PRECISION, 6'd0, idle};
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_setting(logic [5:0] prec, logic [5:0] sc);
    pending_t p;
    p = '{ENTRY_CFG, dau_pkg::OP_ADD, '0, '0, dau_pkg::REG_PRECISION, prec, 0};
    pending_q.insert(pending_q.size(), p);
    p.index = dau_pkg::REG_SCALE;
    p.value = sc;
    pending_q.insert(pending_q.size(), p);
  endtask

  task automatic add_drain();
    pending_t p;
    p = '{ENTRY_DRAIN, dau_pkg::OP_ADD, '0, '0, dau_pkg::REG_PRECISION, 6'd0, 0};
    pending_q.insert(pending_q.size(), p);
  endtask

  always @(posedge clk) begin
    pending_t p;
    logic accepted;
    logic cfg_write;
    cfg_write = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      accepted = start && !busy;
      if (accepted) begin
        expected_q.insert(expected_q.size(),
                          compute_decimal(in_kind, {in_left_high, in_left_low},
                                          {in_right_high, in_right_low},
                                          cur_precision, cur_scale));
      end
      settle = (expected_q.size() == 0 && !accepted) ? settle + 1 : 0;
      if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (pending_q[0].what == ENTRY_OP) begin
        p = pending_q[0];
        if ($urandom_range(0, 99) < p.idle_pct) begin
          start <= 1'b0;
        end else begin
          void'(pending_q.pop_front());
          start <= 1'b1;
          in_kind <= p.kind;
          in_left_low <= p.left[63:0];
          in_left_high <= p.left[127:64];
          in_right_low <= p.right[63:0];
          in_right_high <= p.right[127:64];
        end
      end else begin
        start <= 1'b0;
        if (settle >= SETTLE_CYCLES) begin
          p = pending_q.pop_front();
          settle = 0;
          if (p.what == ENTRY_CFG) begin
            cfg_write = 1'b1;
            cfg_index <= p.index;
            cfg_data <= p.value;
            if (p.index == dau_pkg::REG_PRECISION) cur_precision = p.value;
            else cur_scale = p.value;
          end
        end
      end
    end
    cfg_we <= cfg_write;
  end

  always @(posedge clk) begin
    decimal_result_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction: result %h_%h status %0d", $time,
                 out_result_high, out_result_low, out_status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_result_low !== e.low) begin
          $display("%0t: result_low expected %h actual %h", $time, e.low, out_result_low);
          errors++;
        end
        if (out_result_high !== e.high) begin
          $display("%0t: result_high expected %h actual %h", $time, e.high, out_result_high);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [127:0] most_neg, most_pos, minus_one;
    logic [5:0] precs[7];
    logic [5:0] scales[7];
    logic [2:0] k;
    int r, idle;
    most_neg = {1'b1, 127'd0};
    most_pos = {1'b0, {127{1'b1}}};
    minus_one = '1;
    precs = '{6'd38, 6'd1, 6'd63, 6'd20, 6'd0, 6'd38, 6'd10};
    scales = '{6'd0, 6'd0, 6'd63, 6'd5, 6'd0, 6'd38, 6'd2};

    add_op(dau_pkg::OP_ADD, most_pos, 128'd1, 0);
    add_op(dau_pkg::OP_ADD, 128'd5, -128'd5, 0);
    add_op(dau_pkg::OP_SUB, most_neg, 128'd1, 0);
    add_op(dau_pkg::OP_SUB, 128'd0, 128'd0, 0);
    add_op(dau_pkg::OP_MUL, -128'd12345, 128'd678, 0);
    add_op(dau_pkg::OP_MUL, most_pos, most_pos, 0);
    add_op(dau_pkg::OP_DIV, 128'd100, -128'd7, 0);
    add_op(dau_pkg::OP_DIV, 128'd1, 128'd0, 0);
    add_op(dau_pkg::OP_REM, -128'd100, 128'd7, 0);
    add_op(dau_pkg::OP_REM, 128'd9, 128'd0, 0);
    add_op(dau_pkg::OP_NEG, most_neg, 128'd3, 0);
    add_op(dau_pkg::OP_NEG, 128'd0, minus_one, 0);
    add_op(dau_pkg::OP_ABS, most_neg, 128'd0, 0);
    add_op(dau_pkg::OP_ABS, minus_one, most_pos, 0);
    add_op(OP_UNUSED, most_pos, most_neg, 0);
    add_setting(6'd63, 6'd63);
    add_op(dau_pkg::OP_DIV, most_pos, 128'd3, 0);
    add_op(dau_pkg::OP_DIV, 128'd1, minus_one, 0);
    add_op(dau_pkg::OP_MUL, most_neg, most_neg, 0);
    add_op(dau_pkg::OP_ABS, most_neg, 128'd0, 0);
    add_op(dau_pkg::OP_NEG, most_neg, 128'd0, 0);
    add_setting(6'd0, 6'd1);
    add_op(dau_pkg::OP_ADD, 128'd0, 128'd0, 0);
    add_op(dau_pkg::OP_ADD, 128'd1, 128'd0, 0);
    add_op(dau_pkg::OP_DIV, 128'd0, 128'd5, 0);

    for (int s = 0; s < 7; s++) begin
      add_setting(precs[s], scales[s]);
      for (int n = 0; n < 200; n++) begin
        r = s * 200 + n;
        idle = (r < 470) ? 36 : (r < 940) ? 46 : 0;
        if (r == 700) add_drain();
        k = $urandom_range(0, 20) == 20 ? OP_UNUSED : 3'($urandom_range(0, 6));
        add_op(k, pick_operand(), pick_operand(), idle);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
